>>> rtl/mads_pkg.sv
// Shared constants for the moving average deadband stability unit.
`default_nettype none

package mads_pkg;

   // default sizing
   localparam int DEPTH_DEF       = 8;
   localparam int SAMPLE_BITS_DEF = 24;

   // field widths
   localparam int OPCODE_W   = 2;
   localparam int WEIGHT_W   = 24;
   localparam int FORCE_W    = 24;
   localparam int HELD_W     = 7;
   localparam int DEADBAND_W = 23;
   localparam int TOL_W      = 24;
   localparam int WINDOW_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // item opcodes
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PRESET = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW    = 2'd2;

   // register reset values
   localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 23'd10;
   localparam logic [TOL_W-1:0]      TOL_RST      = 24'd10;
   localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 7'd5;

endpackage

`default_nettype wire

>>> rtl/mads_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mads_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/moving_average_deadband_stability_unit.sv
// Load-cell force smoother: ring average, zero deadband and stability flag.
//
// Input channel req_*: one beat per command. req_tuser carries the opcode
// (sample, clear, preset), req_tdata the signed weight in 0.001 kg units.
// Result channel rsp_*: exactly one beat per command with the filtered
// force, the stable flag and the number of readings held.
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 deadband, 1 stability tolerance, 2 stability window).
// Items are handled one at a time by a sequencer around one ring RAM,
// a min/max/accumulate unit and a one-bit-per-cycle divider.
// Steps per item, accept to result register:
//   sample: ring write, a scan of the held readings, then the divider
//           over the SUM_W-bit sum, SUM_W = SAMPLE_BITS + clog2(DEPTH)
//   clear / ignored ops: a scan only;  preset: a fill of every ring entry
//   (positive weight only), then a scan. The scan makes one RAM read per held reading.
// req_tready is high only while idle; a finished result waits in the
// output register, and the next item may be accepted meanwhile, but its
// result is held back until the previous beat is taken.
// Reset (synchronous, active high) empties the ring, zeroes the force and
// restores the register defaults; no clearing pass is needed.
`default_nettype none

module moving_average_deadband_stability_unit #(
   parameter int DEPTH       = mads_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = mads_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [23:0] weight_value, [31:24] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [23:0] force_res, [24] stable,
                                         // [31:25] readings_held
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
   localparam int DC_W   = $clog2(SUM_W + 1);
   localparam int IN_W   = (SAMPLE_BITS > mads_pkg::WEIGHT_W) ? SAMPLE_BITS
                                                              : mads_pkg::WEIGHT_W;
   localparam int WIDE_W = (SUM_W > mads_pkg::FORCE_W) ? SUM_W : mads_pkg::FORCE_W;
   localparam int MAG_W  = (SUM_W > mads_pkg::DEADBAND_W) ? SUM_W
                                                          : mads_pkg::DEADBAND_W;
   localparam int SPR_W  = (SAMPLE_BITS + 1 > mads_pkg::TOL_W) ? SAMPLE_BITS + 1
                                                               : mads_pkg::TOL_W;

   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [mads_pkg::FORCE_W-1:0] F_MAX =
      {1'b0, {(mads_pkg::FORCE_W-1){1'b1}}};
   localparam logic signed [mads_pkg::FORCE_W-1:0] F_MIN =
      {1'b1, {(mads_pkg::FORCE_W-1){1'b0}}};

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_PREP  = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // configuration registers
   logic [mads_pkg::DEADBAND_W-1:0] deadband_ff;
   logic [mads_pkg::TOL_W-1:0]      tol_ff;
   logic [mads_pkg::WINDOW_W-1:0]   window_ff;

   // control and ring state
   logic [2:0]                       state_ff;
   logic [mads_pkg::OPCODE_W-1:0]    op_ff;
   logic signed [SAMPLE_BITS-1:0]    samp_ff;
   logic [PTR_W-1:0]                 wp_ff;
   logic                             full_ff;
   logic signed [mads_pkg::FORCE_W-1:0] last_force_ff;
   logic [PTR_W-1:0]                 fill_idx_ff;

   // scan
   logic [PTR_W-1:0]                 rd_ptr_ff;
   logic [CNT_W-1:0]                 left_ff;
   logic [CNT_W-1:0]                 win_left_ff;
   logic [CNT_W-1:0]                 win_n_ff;
   logic                             win_ok_ff;
   logic                             rd_vld_ff;
   logic                             rd_win_ff;
   logic                             seen_ff;
   logic signed [SUM_W-1:0]          sum_ff;
   logic signed [SAMPLE_BITS-1:0]    mn_ff;
   logic signed [SAMPLE_BITS-1:0]    mx_ff;

   // divider
   logic [SUM_W-1:0]                 dvd_ff;
   logic [CNT_W-1:0]                 rem_ff;
   logic                             neg_ff;
   logic [DC_W-1:0]                  div_cnt_ff;

   // output register
   logic                             rsp_vld_ff;
   logic [31:0]                      rsp_data_ff;

   // ------------------------------------------------------------------
   logic                             accept;
   logic signed [IN_W-1:0]           w_wide;
   logic signed [SAMPLE_BITS-1:0]    w_clip;
   logic signed [mads_pkg::FORCE_W-1:0] w_force;
   logic [CNT_W-1:0]                 held;
   logic                             win_ok;
   logic [CNT_W-1:0]                 win_n;
   logic signed [SAMPLE_BITS-1:0]    rd_s;
   logic [SAMPLE_BITS-1:0]           rd_data;
   logic                             ram_we;
   logic [PTR_W-1:0]                 ram_waddr;
   logic                             ram_re;
   logic [SUM_W-1:0]                 sum_mag;
   logic [CNT_W:0]                   trial;
   logic                             q_bit;
   logic signed [SUM_W-1:0]          avg;
   logic signed [WIDE_W-1:0]         avg_wide;
   logic signed [mads_pkg::FORCE_W-1:0] avg_sat;
   logic signed [mads_pkg::FORCE_W-1:0] force_out;
   logic signed [SAMPLE_BITS:0]      spread_s;
   logic                             stable;
   logic                             rsp_load;

   assign accept = req_tvalid && req_tready;

   // saturate the incoming weight to the sample range
   always_comb begin
      w_wide = IN_W'($signed(req_tdata[mads_pkg::WEIGHT_W-1:0]));
      if (w_wide > IN_W'(SMP_MAX)) begin
         w_clip = SMP_MAX;
      end else if (w_wide < IN_W'(SMP_MIN)) begin
         w_clip = SMP_MIN;
      end else begin
         w_clip = w_wide[SAMPLE_BITS-1:0];
      end
   end

   // preset force, saturated to the output range
   always_comb begin
      if (IN_W'(w_clip) > IN_W'(F_MAX)) begin
         w_force = F_MAX;
      end else begin
         w_force = mads_pkg::FORCE_W'(w_clip);
      end
   end

   assign held   = full_ff ? CNT_W'(DEPTH) : CNT_W'(wp_ff);
   assign win_ok = (window_ff >= 7'd2) && (window_ff <= 7'(DEPTH));
   assign win_n  = (7'(held) < window_ff) ? held : CNT_W'(window_ff);

   // ring memory
   assign ram_we    = (state_ff == S_WRITE) || (state_ff == S_FILL);
   assign ram_waddr = (state_ff == S_FILL) ? fill_idx_ff : wp_ff;
   assign ram_re    = (state_ff == S_SCAN) && (left_ff != '0);

   mads_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (samp_ff),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign rd_s = rd_data;

   // divider step: restoring, one quotient bit per cycle
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial   = {rem_ff, dvd_ff[SUM_W-1]} - {1'b0, held};
   assign q_bit   = !trial[CNT_W];

   // quotient sign, deadband and output saturation
   always_comb begin
      avg = neg_ff ? -$signed(dvd_ff) : $signed(dvd_ff);
      if (MAG_W'(dvd_ff) < MAG_W'(deadband_ff)) begin
         avg = '0;
      end
      avg_wide = WIDE_W'(avg);
      if (avg_wide > WIDE_W'(F_MAX)) begin
         avg_sat = F_MAX;
      end else if (avg_wide < WIDE_W'(F_MIN)) begin
         avg_sat = F_MIN;
      end else begin
         avg_sat = avg_wide[mads_pkg::FORCE_W-1:0];
      end
   end

   assign force_out = (op_ff == mads_pkg::OP_SAMPLE) ? avg_sat : last_force_ff;

   // window spread check
   assign spread_s = (SAMPLE_BITS+1)'(mx_ff) - (SAMPLE_BITS+1)'(mn_ff);
   always_comb begin
      if (!win_ok_ff) begin
         stable = 1'b0;
      end else if (win_n_ff == '0) begin
         stable = 1'b1;
      end else begin
         stable = SPR_W'($unsigned(spread_s)) <= SPR_W'(tol_ff);
      end
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_vld_ff || rsp_tready);

   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= mads_pkg::DEADBAND_RST;
         tol_ff      <= mads_pkg::TOL_RST;
         window_ff   <= mads_pkg::WINDOW_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mads_pkg::REG_DEADBAND:  deadband_ff <= csr_wdata[mads_pkg::DEADBAND_W-1:0];
            mads_pkg::REG_TOLERANCE: tol_ff      <= csr_wdata[mads_pkg::TOL_W-1:0];
            mads_pkg::REG_WINDOW:    window_ff   <= csr_wdata[mads_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wp_ff         <= '0;
         full_ff       <= 1'b0;
         last_force_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_vld_ff && rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end

         // accumulate and min/max on returning read data
         if (rd_vld_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_s);
            if (rd_win_ff) begin
               seen_ff <= 1'b1;
               if (!seen_ff || rd_s < mn_ff) begin
                  mn_ff <= rd_s;
               end
               if (!seen_ff || rd_s > mx_ff) begin
                  mx_ff <= rd_s;
               end
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff   <= req_tuser;
                  samp_ff <= w_clip;
                  unique case (req_tuser)
                     mads_pkg::OP_SAMPLE: state_ff <= S_WRITE;
                     mads_pkg::OP_CLEAR: begin
                        wp_ff         <= '0;
                        full_ff       <= 1'b0;
                        last_force_ff <= '0;
                        state_ff      <= S_PREP;
                     end
                     mads_pkg::OP_PRESET: begin
                        if (w_clip > 0) begin
                           fill_idx_ff   <= '0;
                           last_force_ff <= w_force;
                           state_ff      <= S_FILL;
                        end else begin
                           state_ff <= S_PREP;
                        end
                     end
                     default: state_ff <= S_PREP;
                  endcase
               end
            end
            S_WRITE: begin
               if (wp_ff == PTR_W'(DEPTH - 1)) begin
                  wp_ff   <= '0;
                  full_ff <= 1'b1;
               end else begin
                  wp_ff <= wp_ff + 1'b1;
               end
               state_ff <= S_PREP;
            end
            S_FILL: begin
               fill_idx_ff <= fill_idx_ff + 1'b1;
               if (fill_idx_ff == PTR_W'(DEPTH - 1)) begin
                  wp_ff    <= '0;
                  full_ff  <= 1'b1;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               // newest entry first, walking backward through the ring
               rd_ptr_ff   <= (wp_ff == '0) ? PTR_W'(DEPTH - 1) : wp_ff - 1'b1;
               left_ff     <= held;
               win_left_ff <= win_n;
               win_n_ff    <= win_n;
               win_ok_ff   <= win_ok;
               sum_ff      <= '0;
               seen_ff     <= 1'b0;
               state_ff    <= S_SCAN;
            end
            S_SCAN: begin
               if (left_ff != '0) begin
                  left_ff   <= left_ff - 1'b1;
                  rd_ptr_ff <= (rd_ptr_ff == '0) ? PTR_W'(DEPTH - 1) : rd_ptr_ff - 1'b1;
                  rd_vld_ff <= 1'b1;
                  rd_win_ff <= (win_left_ff != '0);
                  if (win_left_ff != '0) begin
                     win_left_ff <= win_left_ff - 1'b1;
                  end
               end else begin
                  rd_vld_ff <= 1'b0;
                  if (!rd_vld_ff) begin
                     if (op_ff == mads_pkg::OP_SAMPLE) begin
                        dvd_ff     <= sum_mag;
                        neg_ff     <= sum_ff[SUM_W-1];
                        rem_ff     <= '0;
                        div_cnt_ff <= DC_W'(SUM_W);
                        state_ff   <= S_DIV;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
               end
            end
            S_DIV: begin
               rem_ff     <= q_bit ? trial[CNT_W-1:0] : {rem_ff[CNT_W-2:0], dvd_ff[SUM_W-1]};
               dvd_ff     <= {dvd_ff[SUM_W-2:0], q_bit};
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == DC_W'(1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  last_force_ff <= force_out;
                  rsp_data_ff   <= {7'(held), stable, force_out};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("block stayed ready after accepting a beat");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (held != '0))
      else $error("divide by an empty ring");

   a_window_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && win_n_ff != '0) |-> seen_ff)
      else $error("stability window had readings but none were scanned");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && op_ff == mads_pkg::OP_CLEAR) |=>
         (rsp_tvalid && rsp_tdata[23:0] == '0 && rsp_tdata[31:25] == '0))
      else $error("clear did not report an empty filter");

endmodule

`default_nettype wire
